FILE: rtl/core/psz_pkg.sv
package psz_pkg;

   localparam int MaxWidthDef  = 512;
   localparam int MaxHeightDef = 512;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_DRAW  = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic [2:0] CSR_COL0   = 3'd0;
   localparam logic [2:0] CSR_COL1   = 3'd1;
   localparam logic [2:0] CSR_COL2   = 3'd2;
   localparam logic [2:0] CSR_COL3   = 3'd3;
   localparam logic [2:0] CSR_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_HEIGHT = 3'd5;
   localparam logic [2:0] CSR_BACK   = 3'd6;

   localparam logic [16:0] FAR_DEPTH = 17'h1FFFF;

   // clip coordinates: 16x16 products of four terms, 2^-20 units
   localparam int ClipW = 35;

   // item handed from front to back
   typedef struct packed {
      logic [1:0]  kind;
      logic        visible;
      logic [8:0]  col;
      logic [8:0]  row;
      logic [16:0] depth;
      logic [23:0] colour;
   } job_type;

endpackage

FILE: rtl/core/psz_div.sv
// restoring divider, one quotient bit per cycle: quo = num / den
module psz_div #(
   parameter int NumW = 48,
   parameter int DenW = 40,
   parameter int QuoW = 18
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic            busy,
   output logic            fin,
   output logic [QuoW-1:0] quo
);
   localparam int CntW = $clog2(QuoW + 1);
   localparam int RemW = DenW + 1;

   logic [NumW-1:0] num_ff, num_in;
   logic [DenW-1:0] den_ff, den_in;
   logic [RemW-1:0] rem_ff, rem_in;
   logic [QuoW-1:0] quo_ff, quo_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, fin_ff, fin_in;
   logic [RemW-1:0] trial;

   // numerator shifted so its top bit lines up with the QuoW-bit quotient
   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      trial   = {rem_ff[RemW-2:0], num_ff[NumW-1]};
      if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[QuoW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QuoW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (go) begin
         num_in  = num << (NumW - QuoW);
         den_in  = den;
         // high part of num above the quotient bits is assumed to be below den
         rem_in  = RemW'(num >> QuoW);
         quo_in  = '0;
         cnt_in  = CntW'(QuoW);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign fin  = fin_ff;
   assign quo  = quo_ff;
endmodule

FILE: rtl/core/psz_front.sv
// front: transform, clip, pixel and depth division
module psz_front #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [1:0]            kind,
   input  logic signed [15:0]    pos_x,
   input  logic signed [15:0]    pos_y,
   input  logic signed [15:0]    pos_z,
   input  logic [23:0]           colour,
   input  logic [8:0]            read_col,
   input  logic [8:0]            read_row,
   input  logic [3:0][63:0]      mvp,
   input  logic [9:0]            frame_width,
   input  logic [9:0]            frame_height,
   output logic                  busy,
   output logic                  push,
   output psz_pkg::job_type      job
);
   import psz_pkg::*;

   localparam int SzW  = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH + 1 : MAX_HEIGHT + 1);
   localparam int PosW = ClipW + 1 + 13;  // (c+w)*size
   localparam int DenW = ClipW + 1;
   localparam int ZNumW = ClipW + 16;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_SUM, S_CLIP, S_DIVX, S_DIVY, S_DIVZ, S_OUT
   } state_type;

   state_type   state_ff;
   logic [1:0]  kind_ff;
   logic signed [15:0] px_ff, py_ff, pz_ff;
   logic [23:0] colour_ff;
   logic [8:0]  rcol_ff, rrow_ff;
   logic [1:0]  row_ff;
   logic signed [3:0][ClipW-1:0] clip_ff;
   logic signed [3:0][31:0] prod_ff;
   logic        vis_ff;
   logic [8:0]  col_ff, prow_ff;
   logic [16:0] depth_ff;
   logic        push_ff;
   job_type     job_ff;

   logic [SzW-1:0] w_sz, h_sz;
   logic signed [15:0] cf0, cf1, cf2, cf3;
   logic signed [ClipW-1:0] cx, cy, cz, cw;
   logic        div_go, div_busy, div_fin;
   logic [PosW-1:0] div_num;
   logic [DenW-1:0] div_den;
   logic [17:0] div_quo;
   logic [PosW-1:0] numx, numy;
   logic [ZNumW-1:0] numz;
   logic [8:0]  colc, rowc;

   function automatic logic [SzW-1:0] eff(input logic [9:0] r, input int mx);
      logic [SzW-1:0] v;
      if (r == 10'd0) v = SzW'(1);
      else if (32'(r) > mx) v = SzW'(mx);
      else v = SzW'(r);
      return v;
   endfunction

   assign w_sz = eff(frame_width, MAX_WIDTH);
   assign h_sz = eff(frame_height, MAX_HEIGHT);

   // coefficients of the current matrix row
   assign cf0 = mvp[0][16*row_ff +: 16];
   assign cf1 = mvp[1][16*row_ff +: 16];
   assign cf2 = mvp[2][16*row_ff +: 16];
   assign cf3 = mvp[3][16*row_ff +: 16];

   assign cx = clip_ff[0];
   assign cy = clip_ff[1];
   assign cz = clip_ff[2];
   assign cw = clip_ff[3];

   assign numx = PosW'(cx + cw) * PosW'(w_sz);
   assign numy = PosW'(cy + cw) * PosW'(h_sz);
   assign numz = ZNumW'(cz) << 16;
   assign div_den = DenW'(cw) << 1;

   always_comb begin
      div_num = numx;
      if (state_ff == S_DIVY) div_num = numy;
      else if (state_ff == S_DIVZ) div_num = PosW'(numz) << 1;
   end

   assign div_go = (state_ff == S_DIVX || state_ff == S_DIVY || state_ff == S_DIVZ)
                   && !div_busy && !div_fin;

   psz_div #(.NumW(PosW), .DenW(DenW), .QuoW(18)) u_div (
      .clock(clock), .reset(reset), .go(div_go), .num(div_num), .den(div_den),
      .busy(div_busy), .fin(div_fin), .quo(div_quo)
   );

   always_comb begin
      colc = 9'(div_quo);
      if (div_quo >= 18'(w_sz)) colc = 9'(w_sz - 1'b1);
      rowc = 9'(div_quo);
      if (div_quo >= 18'(h_sz)) rowc = 9'(h_sz - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         push_ff  <= 1'b0;
      end else begin
         push_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  kind_ff <= kind; px_ff <= pos_x; py_ff <= pos_y; pz_ff <= pos_z;
                  colour_ff <= colour; rcol_ff <= read_col; rrow_ff <= read_row;
                  row_ff <= 2'd0;
                  state_ff <= (kind == KIND_DRAW) ? S_MUL : S_OUT;
               end
            end
            S_MUL: begin
               prod_ff[0] <= cf0 * px_ff;
               prod_ff[1] <= cf1 * py_ff;
               prod_ff[2] <= cf2 * pz_ff;
               prod_ff[3] <= 32'(cf3) <<< 8;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               // products are signed; elements of the packed array are not
               clip_ff[row_ff] <= ClipW'($signed(prod_ff[0])) + ClipW'($signed(prod_ff[1]))
                                + ClipW'($signed(prod_ff[2])) + ClipW'($signed(prod_ff[3]));
               row_ff <= row_ff + 1'b1;
               state_ff <= (row_ff == 2'd3) ? S_CLIP : S_MUL;
            end
            S_CLIP: begin
               vis_ff <= (cw > 0) && (cx >= -cw) && (cx <= cw) && (cy >= -cw)
                         && (cy <= cw) && (cz >= 0) && (cz <= cw);
               if ((cw > 0) && (cx >= -cw) && (cx <= cw) && (cy >= -cw)
                   && (cy <= cw) && (cz >= 0) && (cz <= cw))
                  state_ff <= S_DIVX;
               else
                  state_ff <= S_OUT;
            end
            S_DIVX: if (div_fin) begin col_ff <= colc; state_ff <= S_DIVY; end
            S_DIVY: if (div_fin) begin prow_ff <= rowc; state_ff <= S_DIVZ; end
            S_DIVZ: if (div_fin) begin depth_ff <= 17'(div_quo); state_ff <= S_OUT; end
            S_OUT: begin
               push_ff <= 1'b1;
               job_ff.kind   <= kind_ff;
               job_ff.colour <= colour_ff;
               job_ff.depth  <= depth_ff;
               job_ff.visible <= 1'b0;
               job_ff.col <= '0;
               job_ff.row <= '0;
               if (kind_ff == KIND_DRAW && vis_ff) begin
                  job_ff.visible <= 1'b1;
                  job_ff.col <= col_ff;
                  job_ff.row <= prow_ff;
               end else if (kind_ff == KIND_READ) begin
                  job_ff.visible <= (32'(rcol_ff) < 32'(w_sz)) && (32'(rrow_ff) < 32'(h_sz));
                  job_ff.col <= rcol_ff;
                  job_ff.row <= rrow_ff;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_IDLE && take && kind == KIND_DRAW) vis_ff <= 1'b0;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign push = push_ff;
   assign job  = job_ff;
endmodule

FILE: rtl/core/psz_back.sv
// back: queue, clear sweep, depth test and pixel read
module psz_back #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  psz_pkg::job_type job,
   input  logic [23:0]      background,
   output logic             full,
   output logic             idle,
   output logic             rsp_valid,
   output logic [1:0]       rsp_done_kind,
   output logic             rsp_drawn,
   output logic [8:0]       rsp_pixel_col,
   output logic [8:0]       rsp_pixel_row,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out
);
   import psz_pkg::*;

   localparam int Pixels = MAX_WIDTH * MAX_HEIGHT;
   localparam int AddrW  = (Pixels > 1) ? $clog2(Pixels) : 1;
   localparam int ColW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   typedef enum logic [2:0] { B_IDLE, B_CLEAR, B_RD, B_WAIT, B_WR } state_type;

   logic [16:0] depth_mem  [Pixels];
   logic [23:0] colour_mem [Pixels];
   logic [16:0] depth_rd_ff;
   logic [23:0] colour_rd_ff;

   job_type    q_ff [2];
   logic       qw_ff, qr_ff;
   logic [1:0] qn_ff;
   job_type    cur_ff;
   state_type  state_ff;
   logic [AddrW:0] clr_ff;
   logic       cleared_ff;

   logic        we;
   logic [AddrW-1:0] waddr, raddr;
   logic [16:0] wdepth;
   logic [23:0] wcolour;
   logic        in_range;
   logic [31:0] idx;
   logic        pop;

   assign idx = 32'(cur_ff.row) * 32'(MAX_WIDTH) + 32'(cur_ff.col);
   assign in_range = (32'(cur_ff.col) < 32'(MAX_WIDTH)) && (idx < 32'(Pixels));
   assign raddr = AddrW'(idx);
   assign pop = (state_ff == B_IDLE) && (qn_ff != 2'd0);

   always_comb begin
      we = 1'b0; waddr = raddr; wdepth = cur_ff.depth; wcolour = cur_ff.colour;
      if (state_ff == B_CLEAR) begin
         we = 1'b1; waddr = clr_ff[AddrW-1:0]; wdepth = FAR_DEPTH; wcolour = background;
      end else if (state_ff == B_WR && cur_ff.kind == KIND_DRAW && cur_ff.visible
                   && cleared_ff && in_range && cur_ff.depth < depth_rd_ff) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         depth_mem[waddr]  <= wdepth;
         colour_mem[waddr] <= wcolour;
      end
      depth_rd_ff  <= depth_mem[raddr];
      colour_rd_ff <= colour_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qw_ff <= 1'b0; qr_ff <= 1'b0; qn_ff <= '0;
         state_ff <= B_IDLE; cleared_ff <= 1'b0; rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (push) begin
            q_ff[qw_ff] <= job;
            qw_ff <= ~qw_ff;
         end
         if (pop) qr_ff <= ~qr_ff;
         qn_ff <= qn_ff + {1'b0, push} - {1'b0, pop};
         case (state_ff)
            B_IDLE: if (pop) begin
               cur_ff <= q_ff[qr_ff];
               clr_ff <= '0;
               case (q_ff[qr_ff].kind)
                  KIND_CLEAR: state_ff <= B_CLEAR;
                  KIND_DRAW:  state_ff <= q_ff[qr_ff].visible ? B_RD : B_WR;
                  KIND_READ:  state_ff <= B_RD;
                  default:    state_ff <= B_IDLE;
               endcase
            end
            B_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AddrW+1)'(Pixels - 1)) begin
                  state_ff <= B_WR; cleared_ff <= 1'b1;
               end
            end
            B_RD:   state_ff <= B_WAIT;
            B_WAIT: state_ff <= B_WR;
            B_WR: begin
               rsp_valid     <= 1'b1;
               rsp_done_kind <= cur_ff.kind;
               rsp_pixel_col <= cur_ff.col;
               rsp_pixel_row <= cur_ff.row;
               rsp_drawn     <= we && (cur_ff.kind == KIND_DRAW);
               {rsp_blue_out, rsp_green_out, rsp_red_out} <= '0;
               if (cur_ff.kind == KIND_READ && cur_ff.visible && in_range && cleared_ff)
                  {rsp_blue_out, rsp_green_out, rsp_red_out} <= colour_rd_ff;
               state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign full = (qn_ff != 2'd0);
   assign idle = (state_ff == B_IDLE) && (qn_ff == 2'd0);
   // unused upper column bits kept for generality
   logic unused_col;
   assign unused_col = ^cur_ff.col[8:ColW > 8 ? 8 : ColW];
endmodule

FILE: rtl/core/point_splat_zbuffer.sv
// point splat z-buffer: clear, draw point, read pixel; one result per item, kind three ignored
// draw path: transform of each matrix row, a clip step, three divisions (column, row, depth),
//   then queue and depth test; a culled draw skips the divisions, a clear sweeps MAX_WIDTH*MAX_HEIGHT
// throughput: one item in the front at a time; front and back overlap through a two-entry queue
// reset: synchronous, resets control and the config registers; pixel stores read as zero until first clear
// results strobe on rsp_valid for one cycle; the receiver cannot stall
module point_splat_zbuffer #(
   parameter int MAX_WIDTH  = psz_pkg::MaxWidthDef,
   parameter int MAX_HEIGHT = psz_pkg::MaxHeightDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [8:0]  req_read_col,
   input  logic [8:0]  req_read_row,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_done_kind,
   output logic        rsp_drawn,
   output logic [8:0]  rsp_pixel_col,
   output logic [8:0]  rsp_pixel_row,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out
);
   import psz_pkg::*;

   logic [3:0][63:0] mvp_ff;
   logic [9:0]  width_ff, height_ff;
   logic [23:0] back_ff;

   logic    front_busy, push, q_full, back_idle, take;
   job_type job;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mvp_ff <= '0; width_ff <= 10'd512; height_ff <= 10'd512; back_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COL0:   mvp_ff[0] <= csr_data;
            CSR_COL1:   mvp_ff[1] <= csr_data;
            CSR_COL2:   mvp_ff[2] <= csr_data;
            CSR_COL3:   mvp_ff[3] <= csr_data;
            CSR_WIDTH:  width_ff  <= csr_data[9:0];
            CSR_HEIGHT: height_ff <= csr_data[9:0];
            CSR_BACK:   back_ff   <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // front waits while the queue holds an item; kind three is swallowed
   assign busy = front_busy || q_full;
   assign take = start && !busy && (req_kind != KIND_NONE);

   psz_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset), .take(take), .kind(req_kind),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .colour({req_blue_in, req_green_in, req_red_in}),
      .read_col(req_read_col), .read_row(req_read_row),
      .mvp(mvp_ff), .frame_width(width_ff), .frame_height(height_ff),
      .busy(front_busy), .push(push), .job(job)
   );

   psz_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock(clock), .reset(reset), .push(push), .job(job), .background(back_ff),
      .full(q_full), .idle(back_idle),
      .rsp_valid(rsp_valid), .rsp_done_kind(rsp_done_kind), .rsp_drawn(rsp_drawn),
      .rsp_pixel_col(rsp_pixel_col), .rsp_pixel_row(rsp_pixel_row),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out)
   );

   logic unused_idle;
   assign unused_idle = back_idle;
endmodule

FILE: verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import psz_pkg::*;

   localparam int STORE_W  = 512;
   localparam int STORE_H  = 512;
   localparam int PIXELS   = STORE_W * STORE_H;
   localparam int SETTLE   = 100;  // settling wait, longer than any item takes apart from a clear

   // identity matrix columns, Q4.12 one on the diagonal
   localparam logic [63:0] ID_COL0 = 64'h0000_0000_0000_1000;
   localparam logic [63:0] ID_COL1 = 64'h0000_0000_1000_0000;
   localparam logic [63:0] ID_COL2 = 64'h0000_1000_0000_0000;
   localparam logic [63:0] ID_COL3 = 64'h1000_0000_0000_0000;

   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [7:0]         r;
      logic [7:0]         g;
      logic [7:0]         b;
      logic [8:0]         col;
      logic [8:0]         row;
   } splat_item_t;

   typedef struct {
      logic [1:0] kind;
      logic       drawn;
      logic [8:0] col;
      logic [8:0] row;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } splat_result_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic signed [15:0] req_pos_x;
   logic signed [15:0] req_pos_y;
   logic signed [15:0] req_pos_z;
   logic [7:0]  req_red_in;
   logic [7:0]  req_green_in;
   logic [7:0]  req_blue_in;
   logic [8:0]  req_read_col;
   logic [8:0]  req_read_row;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;
   logic        rsp_valid;
   logic [1:0]  rsp_done_kind;
   logic        rsp_drawn;
   logic [8:0]  rsp_pixel_col;
   logic [8:0]  rsp_pixel_row;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;

   point_splat_zbuffer DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .req_red_in(req_red_in), .req_green_in(req_green_in),
      .req_blue_in(req_blue_in), .req_read_col(req_read_col),
      .req_read_row(req_read_row), .csr_we(csr_we), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_done_kind(rsp_done_kind),
      .rsp_drawn(rsp_drawn), .rsp_pixel_col(rsp_pixel_col),
      .rsp_pixel_row(rsp_pixel_row), .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out), .rsp_blue_out(rsp_blue_out)
   );

   // shadow copy of the block's registers and pixel stores
   logic [63:0] mvp_shadow [4];
   logic [9:0]  width_shadow;
   logic [9:0]  height_shadow;
   logic [23:0] back_shadow;
   logic [16:0] depth_mem  [PIXELS];
   logic [23:0] colour_mem [PIXELS];

   splat_result_t pending_results [$];
   int error_count;
   int idle_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop: three full-store clears plus the item traffic, taken several times over
   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int frame_size(logic [9:0] reg_val, int limit);
      if (reg_val == 0) return 1;
      if (reg_val > limit) return limit;
      return int'(reg_val);
   endfunction

   function automatic longint mvp_coef(int c, int r);
      logic signed [15:0] v;
      v = mvp_shadow[c][16*r +: 16];
      return longint'(v);
   endfunction

   // pixel index along one axis, clamped at the far edge
   function automatic int clip_to_pixel(longint c, longint w, int size);
      longint p;
      p = ((c + w) * longint'(size)) / (2 * w);
      if (p >= size) p = size - 1;
      return int'(p);
   endfunction

   // works out the result of one accepted item and updates the shadow stores
   function automatic bit splat_predict(splat_item_t it, output splat_result_t res);
      longint pv [4];
      longint cv [4];
      longint w;
      int wpx, hpx, pc, pr, idx;
      logic [16:0] zq;
      logic [23:0] colour;
      res = '{default: '0};
      res.kind = it.kind;
      wpx = frame_size(width_shadow, STORE_W);
      hpx = frame_size(height_shadow, STORE_H);
      if (it.kind == KIND_NONE) return 1'b0;
      if (it.kind == KIND_CLEAR) begin
         // whole store, not only the frame in use
         for (int i = 0; i < PIXELS; i++) begin
            depth_mem[i]  = FAR_DEPTH;
            colour_mem[i] = back_shadow;
         end
      end else if (it.kind == KIND_DRAW) begin
         pv[0] = longint'(it.x);
         pv[1] = longint'(it.y);
         pv[2] = longint'(it.z);
         pv[3] = 256;
         for (int r = 0; r < 4; r++) begin
            cv[r] = 0;
            for (int c = 0; c < 4; c++) cv[r] += mvp_coef(c, r) * pv[c];
         end
         w = cv[3];
         if (w > 0 && cv[0] >= -w && cv[0] <= w && cv[1] >= -w && cv[1] <= w &&
             cv[2] >= 0 && cv[2] <= w) begin
            pc  = clip_to_pixel(cv[0], w, wpx);
            pr  = clip_to_pixel(cv[1], w, hpx);
            idx = pr * STORE_W + pc;
            zq  = 17'((cv[2] <<< 16) / w);
            res.col = 9'(pc);
            res.row = 9'(pr);
            // strict less: a tie keeps the stored pixel
            if (zq < depth_mem[idx]) begin
               depth_mem[idx]  = zq;
               colour_mem[idx] = {it.b, it.g, it.r};
               res.drawn = 1'b1;
            end
         end
      end else begin
         res.col = it.col;
         res.row = it.row;
         if (it.col < wpx && it.row < hpx) begin
            colour = colour_mem[int'(it.row) * STORE_W + int'(it.col)];
            {res.b, res.g, res.r} = colour;
         end
      end
      return 1'b1;
   endfunction

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // each strobed result is checked against the oldest expectation
   always @(posedge clock) begin
      splat_result_t exp_res;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: expected none, actual kind %0d", $time,
                     rsp_done_kind);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            check_field("done_kind", exp_res.kind, rsp_done_kind);
            check_field("drawn", exp_res.drawn, rsp_drawn);
            check_field("pixel_col", exp_res.col, rsp_pixel_col);
            check_field("pixel_row", exp_res.row, rsp_pixel_row);
            check_field("red_out", exp_res.r, rsp_red_out);
            check_field("green_out", exp_res.g, rsp_green_out);
            check_field("blue_out", exp_res.b, rsp_blue_out);
         end
      end
   end

   // start stays high between back-to-back items; idling lowers it
   task automatic send_item(splat_item_t it);
      splat_result_t res;
      int gap;
      req_kind     <= it.kind;
      req_pos_x    <= it.x;
      req_pos_y    <= it.y;
      req_pos_z    <= it.z;
      req_red_in   <= it.r;
      req_green_in <= it.g;
      req_blue_in  <= it.b;
      req_read_col <= it.col;
      req_read_row <= it.row;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      if (splat_predict(it, res)) pending_results.push_back(res);
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every result is back and the block has settled
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] index, logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index <= CSR_COL3) mvp_shadow[index] = data;
      else if (index == CSR_WIDTH) width_shadow = data[9:0];
      else if (index == CSR_HEIGHT) height_shadow = data[9:0];
      else if (index == CSR_BACK) back_shadow = data[23:0];
   endtask

   task automatic load_identity;
      write_csr(CSR_COL0, ID_COL0);
      write_csr(CSR_COL1, ID_COL1);
      write_csr(CSR_COL2, ID_COL2);
      write_csr(CSR_COL3, ID_COL3);
   endtask

   function automatic splat_item_t make_draw(int x, int y, int z, logic [23:0] colour);
      splat_item_t it;
      it = '{default: '0};
      it.kind = KIND_DRAW;
      it.x = 16'(x);
      it.y = 16'(y);
      it.z = 16'(z);
      {it.b, it.g, it.r} = colour;
      return it;
   endfunction

   function automatic splat_item_t make_read(int col, int row);
      splat_item_t it;
      it = '{default: '0};
      it.kind = KIND_READ;
      it.col = 9'(col);
      it.row = 9'(row);
      return it;
   endfunction

   function automatic splat_item_t make_clear;
      splat_item_t it;
      it = '{default: '0};
      it.kind = KIND_CLEAR;
      return it;
   endfunction

   // random point: mostly near the unit cube, sometimes any bit pattern
   function automatic splat_item_t random_draw;
      splat_item_t it;
      it = make_draw(int'($urandom_range(600)) - 300, int'($urandom_range(600)) - 300,
                     int'($urandom_range(340)) - 40, 24'($urandom));
      if ($urandom_range(9) == 0) begin
         it.x = 16'($urandom);
         it.y = 16'($urandom);
         it.z = 16'($urandom);
      end
      return it;
   endfunction

   function automatic splat_item_t random_read;
      int wpx, hpx;
      wpx = frame_size(width_shadow, STORE_W);
      hpx = frame_size(height_shadow, STORE_H);
      if ($urandom_range(9) < 3) return make_read($urandom_range(511), $urandom_range(511));
      return make_read($urandom_range(wpx + 1), $urandom_range(hpx + 1)) ;
   endfunction

   function automatic logic [15:0] rand_coef(int lo, int hi);
      return 16'(lo + int'($urandom_range(hi - lo)));
   endfunction

   // projective matrix: scaled diagonal, small shear and a perspective term
   task automatic load_random_projection;
      logic [63:0] cols [4];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            cols[c][16*r +: 16] = (c == r) ? rand_coef(2048, 8192) : rand_coef(-512, 512);
      cols[3][63:48] = rand_coef(2048, 8192);
      cols[2][63:48] = rand_coef(-1024, 1024);
      for (int c = 0; c < 4; c++) write_csr(3'(c), cols[c]);
   endtask

   task automatic load_random_frame;
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) begin
         // small frames crowd points onto few pixels so depth tests collide
         write_csr(CSR_WIDTH, 64'($urandom_range(1, 16)));
         write_csr(CSR_HEIGHT, 64'($urandom_range(1, 16)));
      end else begin
         write_csr(CSR_WIDTH, 64'($urandom_range(1023)));
         write_csr(CSR_HEIGHT, 64'($urandom_range(1023)));
      end
      write_csr(CSR_BACK, {$urandom, $urandom});
   endtask

   // pixel stores are zero: nothing is drawn, reads give zero
   task automatic test_before_first_clear;
      load_identity();
      write_csr(CSR_BACK, 64'h00_A5_5A_C3);
      send_item(make_draw(0, 0, 128, 24'hFFFFFF));
      send_item(make_read(256, 256));
      send_item(make_read(0, 0));
      drain();
   endtask

   task automatic test_directed_points;
      splat_item_t it;
      send_item(make_clear());
      send_item(make_read(511, 511));
      send_item(make_draw(0, 0, 128, 24'h112233));
      send_item(make_draw(0, 0, 128, 24'h445566));   // same depth, tie loses
      send_item(make_draw(0, 0, 64, 24'hFFFFFF));    // nearer wins
      send_item(make_draw(0, 0, 200, 24'h000000));   // farther loses
      send_item(make_read(256, 256));
      send_item(make_draw(256, 256, 256, 24'hFF00FF)); // far corner, clamped
      send_item(make_draw(-256, -256, 0, 24'h00FF00)); // near corner, depth zero
      send_item(make_draw(257, 0, 10, 24'h0));         // just outside in x
      send_item(make_draw(0, -257, 10, 24'h0));        // just outside in y
      send_item(make_draw(0, 0, -1, 24'h0));           // behind near plane
      send_item(make_draw(0, 0, 257, 24'h0));          // beyond far plane
      send_item(make_draw(-32768, 32767, -32768, 24'h0));
      send_item(make_draw(32767, -32768, 32767, 24'h0));
      it = make_draw(0, 0, 0, 24'h0);
      it.kind = KIND_NONE;                             // ignored, no result
      send_item(it);
      send_item(make_read(0, 0));
      send_item(make_read(511, 0));
      drain();
   endtask

   task automatic test_frame_limits;
      write_csr(CSR_WIDTH, 64'd0);        // treated as one
      write_csr(CSR_HEIGHT, 64'd1023);    // saturates to the store
      send_item(make_draw(100, -100, 30, 24'hABCDEF));
      send_item(make_read(0, 100));
      send_item(make_read(1, 100));       // outside the frame in use
      drain();
      write_csr(CSR_WIDTH, 64'd512);
      write_csr(CSR_HEIGHT, 64'd1);
      send_item(make_draw(255, 255, 40, 24'h123456));
      send_item(make_read(511, 0));
      send_item(make_read(511, 1));
      drain();
   endtask

   task automatic test_negative_w;
      write_csr(CSR_COL3, 64'hF000_0000_0000_0000);  // w = -1
      send_item(make_draw(0, 0, 0, 24'hFFFFFF));
      drain();
      write_csr(CSR_COL3, 64'h0000_0000_0000_0000);  // w = 0
      send_item(make_draw(0, 0, 0, 24'hFFFFFF));
      drain();
      load_identity();
   endtask

   // arbitrary matrices: every coefficient bit toggles, most points cull
   task automatic test_random_matrices;
      for (int m = 0; m < 5; m++) begin
         for (int c = 0; c < 4; c++) write_csr(3'(c), {$urandom, $urandom});
         for (int i = 0; i < 6; i++) send_item(random_draw());
         drain();
      end
   endtask

   task automatic run_random_phase(int count, int pct, bit with_clear, bit projective);
      int pick;
      idle_pct = pct;
      if (projective) load_random_projection();
      else load_identity();
      load_random_frame();
      if (with_clear) send_item(make_clear());
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 68) send_item(random_draw());
         else if (pick < 96) send_item(random_read());
         else begin
            splat_item_t it;
            it = random_draw();
            it.kind = KIND_NONE;
            send_item(it);
         end
      end
      drain();
   endtask

   initial begin
      error_count   = 0;
      idle_pct      = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = KIND_NONE;
      req_pos_x     = '0;
      req_pos_y     = '0;
      req_pos_z     = '0;
      req_red_in    = '0;
      req_green_in  = '0;
      req_blue_in   = '0;
      req_read_col  = '0;
      req_read_row  = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_COL0;
      csr_data      = '0;
      for (int c = 0; c < 4; c++) mvp_shadow[c] = '0;
      width_shadow  = 10'd512;
      height_shadow = 10'd512;
      back_shadow   = '0;
      for (int i = 0; i < PIXELS; i++) begin
         depth_mem[i]  = '0;
         colour_mem[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_before_first_clear();
      test_directed_points();
      test_frame_limits();
      test_negative_w();
      test_random_matrices();
      // idling phases: none, heavy, none, light
      run_random_phase(250, 0, 1'b1, 1'b0);
      run_random_phase(250, 83, 1'b0, 1'b1);
      run_random_phase(250, 0, 1'b1, 1'b1);
      run_random_phase(250, 19, 1'b0, 1'b0);

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/psz_pkg.sv
rtl/core/psz_div.sv
rtl/core/psz_front.sv
rtl/core/psz_back.sv
rtl/core/point_splat_zbuffer.sv
verif/tb_top.sv
